// ----- hw/rtl/mfau_pkg.sv -----
// ----------------------------------------------------------------------------
// Motor feedback angle unwrapper package
// Beat types, slot codes, register indexes and unwrap constants shared by
// the channel interfaces and the top level.
// ----------------------------------------------------------------------------
package mfau_pkg;

   // Field widths fixed by the frame format.
   localparam int ID_W    = 11;
   localparam int WORD_W  = 16;
   localparam int TEMP_W  = 8;
   localparam int TURN_W  = 32;
   localparam int COUNT_W = 6;
   localparam int SLOT_W  = 2;
   localparam int IDX_W   = 2;

   // Number of identifier registers, one per motor role.
   localparam int ID_REGS = 4;

   // Slot codes, in priority order.
   localparam logic [SLOT_W-1:0] SLOT_CHASSIS = 2'd0;
   localparam logic [SLOT_W-1:0] SLOT_TRIGGER = 2'd1;
   localparam logic [SLOT_W-1:0] SLOT_YAW     = 2'd2;
   localparam logic [SLOT_W-1:0] SLOT_PITCH   = 2'd3;

   // Configuration register indexes.
   localparam logic [IDX_W-1:0] CSR_CHASSIS_ID = 2'd0;
   localparam logic [IDX_W-1:0] CSR_TRIGGER_ID = 2'd1;
   localparam logic [IDX_W-1:0] CSR_YAW_ID     = 2'd2;
   localparam logic [IDX_W-1:0] CSR_PITCH_ID   = 2'd3;

   // Identifier values after reset.
   localparam logic [ID_W-1:0] RST_CHASSIS_ID = 11'd513;
   localparam logic [ID_W-1:0] RST_TRIGGER_ID = 11'd515;
   localparam logic [ID_W-1:0] RST_YAW_ID     = 11'd517;
   localparam logic [ID_W-1:0] RST_PITCH_ID   = 11'd518;

   // Encoder unwrap: one turn is 8192 counts, half a turn is the jump limit.
   localparam int                        TURN_SHIFT = 13;
   localparam logic signed [WORD_W:0]    HALF_TURN  = 17'sd4096;
   localparam logic signed [WORD_W:0]    NEG_HALF   = -17'sd4096;

   // One received frame.
   typedef struct packed {
      logic [ID_W-1:0]          std_id;
      logic [WORD_W-1:0]        angle_word;
      logic signed [WORD_W-1:0] second_word;
      logic signed [WORD_W-1:0] third_word;
      logic [TEMP_W-1:0]        temp_byte;
   } req_beat_type;

   // One motor status result.
   typedef struct packed {
      logic                     matched;
      logic [SLOT_W-1:0]        motor_slot;
      logic                     calibrating;
      logic [WORD_W-1:0]        angle_now;
      logic signed [WORD_W-1:0] speed_now;
      logic signed [WORD_W-1:0] current_now;
      logic                     current_kind;
      logic [TEMP_W-1:0]        temperature_now;
      logic signed [TURN_W-1:0] turn_count;
      logic signed [TURN_W-1:0] multi_turn_angle;
   } rsp_beat_type;

endpackage

// ----- hw/rtl/mfau_req_if.sv -----
// ----------------------------------------------------------------------------
// Frame request channel
// Valid/ready channel that carries one received CAN frame per beat.
// ----------------------------------------------------------------------------
interface mfau_req_if;
   import mfau_pkg::*;

   logic         valid;
   logic         ready;
   req_beat_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);

endinterface

// ----- hw/rtl/mfau_rsp_if.sv -----
// ----------------------------------------------------------------------------
// Motor status response channel
// Valid/ready channel that carries one motor status result per beat.
// ----------------------------------------------------------------------------
interface mfau_rsp_if;
   import mfau_pkg::*;

   logic         valid;
   logic         ready;
   rsp_beat_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);

endinterface

// ----- hw/rtl/motor_feedback_angle_unwrapper_top.sv -----
// ----------------------------------------------------------------------------
// Motor feedback angle unwrapper
// Matches received frames against the motor identifiers, captures the
// power-on offset, unpacks feedback and keeps a multi-turn encoder angle.
//
//   Channel  Direction  Beat
//   req_ch   in         std_id, angle_word, second_word, third_word, temp_byte
//   rsp_ch   out        matched, slot, calibrating, stored feedback, angles
//   csr_*    in         write of one motor identifier, no read-back
//
// A frame moves from the input register into the result register, and one
// frame is taken per cycle while the result side does not stall. The per-slot
// state is read and written in that one step, so a frame sees the update of
// the frame just before it.
// A stalled result holds in the result register; the input register still
// fills behind it. Reset is synchronous and clears all motor state at once.
// ----------------------------------------------------------------------------
module motor_feedback_angle_unwrapper_top #(
   parameter int MOTOR_SLOTS  = 4,
   parameter int CALIB_FRAMES = 51
) (
   input  logic                           clock,
   input  logic                           reset,
   mfau_req_if.sink                       req_ch,
   mfau_rsp_if.source                     rsp_ch,
   input  logic                           csr_wr_en,
   input  logic [mfau_pkg::IDX_W-1:0]     csr_index,
   input  logic [mfau_pkg::ID_W-1:0]      csr_wr_data
);
   import mfau_pkg::*;

   // Only the four identifier roles can ever match.
   localparam int SLOTS_USED = (MOTOR_SLOTS < ID_REGS) ? MOTOR_SLOTS : ID_REGS;
   localparam logic [COUNT_W-1:0] CALIB_LAST = COUNT_W'(CALIB_FRAMES);

   // Identifier registers.
   logic [ID_W-1:0] id_ff [ID_REGS];

   // Per-slot motor state.
   logic [WORD_W-1:0]  angle_ff   [SLOTS_USED];
   logic [WORD_W-1:0]  offset_ff  [SLOTS_USED];
   logic [TURN_W-1:0]  turn_ff    [SLOTS_USED];
   logic [COUNT_W-1:0] count_ff   [SLOTS_USED];
   logic [WORD_W-1:0]  speed_ff   [SLOTS_USED];
   logic [WORD_W-1:0]  current_ff [SLOTS_USED];
   logic [TEMP_W-1:0]  temp_ff    [SLOTS_USED];

   // Input and result registers.
   logic         st_valid_ff;
   req_beat_type st_beat_ff;
   logic         rsp_valid_ff;
   rsp_beat_type rsp_beat_ff;
   rsp_beat_type rsp_beat_in;

   // Selected slot and its next state.
   logic [SLOTS_USED-1:0] hit;
   logic                  found;
   logic [SLOT_W-1:0]     sel_slot;
   logic [WORD_W-1:0]     sel_angle;
   logic [WORD_W-1:0]     sel_offset;
   logic [TURN_W-1:0]     sel_turn;
   logic [COUNT_W-1:0]    sel_count;
   logic [WORD_W-1:0]     sel_speed;
   logic [WORD_W-1:0]     sel_current;
   logic [TEMP_W-1:0]     sel_temp;
   logic                  calib;
   logic signed [WORD_W:0] diff;
   logic [WORD_W-1:0]     angle_in;
   logic [WORD_W-1:0]     offset_in;
   logic [TURN_W-1:0]     turn_in;
   logic [COUNT_W-1:0]    count_in;
   logic [WORD_W-1:0]     speed_in;
   logic [WORD_W-1:0]     current_in;
   logic [TEMP_W-1:0]     temp_in;
   logic [TURN_W-1:0]     total;

   // Handshake flow control.
   logic out_free;
   logic adv;

   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign adv          = st_valid_ff && out_free;
   assign req_ch.ready = !st_valid_ff || out_free;
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.data  = rsp_beat_ff;

   // Identifier register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         id_ff[CSR_CHASSIS_ID] <= RST_CHASSIS_ID;
         id_ff[CSR_TRIGGER_ID] <= RST_TRIGGER_ID;
         id_ff[CSR_YAW_ID]     <= RST_YAW_ID;
         id_ff[CSR_PITCH_ID]   <= RST_PITCH_ID;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_CHASSIS_ID: id_ff[CSR_CHASSIS_ID] <= csr_wr_data;
            CSR_TRIGGER_ID: id_ff[CSR_TRIGGER_ID] <= csr_wr_data;
            CSR_YAW_ID:     id_ff[CSR_YAW_ID]     <= csr_wr_data;
            CSR_PITCH_ID:   id_ff[CSR_PITCH_ID]   <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // Input register: refills whenever its beat moves on or it is empty.
   always_ff @(posedge clock) begin
      if (reset) begin
         st_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         st_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.ready && req_ch.valid) begin
         st_beat_ff <= req_ch.data;
      end
   end

   // Identifier match, lowest slot wins, and read of the winning slot.
   always_comb begin
      hit         = '0;
      found       = 1'b0;
      sel_slot    = '0;
      sel_angle   = '0;
      sel_offset  = '0;
      sel_turn    = '0;
      sel_count   = '0;
      sel_speed   = '0;
      sel_current = '0;
      sel_temp    = '0;
      for (int s = 0; s < SLOTS_USED; s++) begin
         if (!found && id_ff[s] == st_beat_ff.std_id) begin
            hit[s] = 1'b1;
            found  = 1'b1;
         end
      end
      for (int s = 0; s < SLOTS_USED; s++) begin
         if (hit[s]) begin
            sel_slot    = sel_slot | SLOT_W'(s);
            sel_angle   = sel_angle | angle_ff[s];
            sel_offset  = sel_offset | offset_ff[s];
            sel_turn    = sel_turn | turn_ff[s];
            sel_count   = sel_count | count_ff[s];
            sel_speed   = sel_speed | speed_ff[s];
            sel_current = sel_current | current_ff[s];
            sel_temp    = sel_temp | temp_ff[s];
         end
      end
   end

   // Offset capture or feedback unpack, then the turn unwrap.
   always_comb begin
      calib      = sel_count < CALIB_LAST;
      diff       = $signed({1'b0, st_beat_ff.angle_word}) - $signed({1'b0, sel_angle});
      angle_in   = st_beat_ff.angle_word;
      offset_in  = sel_offset;
      turn_in    = sel_turn;
      count_in   = CALIB_LAST;
      speed_in   = st_beat_ff.second_word;
      current_in = st_beat_ff.third_word;
      temp_in    = (sel_slot == SLOT_TRIGGER) ? sel_temp : st_beat_ff.temp_byte;
      if (calib) begin
         offset_in  = st_beat_ff.angle_word;
         count_in   = sel_count + COUNT_W'(1);
         speed_in   = sel_speed;
         current_in = sel_current;
         temp_in    = sel_temp;
      end else if (diff > HALF_TURN) begin
         turn_in = sel_turn - TURN_W'(1);
      end else if (diff < NEG_HALF) begin
         turn_in = sel_turn + TURN_W'(1);
      end
      total = {turn_in[TURN_W-TURN_SHIFT-1:0], {TURN_SHIFT{1'b0}}}
              + TURN_W'(angle_in) - TURN_W'(offset_in);
   end

   // Result beat; an unmatched frame gives an all-zero beat.
   always_comb begin
      rsp_beat_in = '0;
      if (found) begin
         rsp_beat_in.matched          = 1'b1;
         rsp_beat_in.motor_slot       = sel_slot;
         rsp_beat_in.calibrating      = calib;
         rsp_beat_in.angle_now        = angle_in;
         rsp_beat_in.speed_now        = speed_in;
         rsp_beat_in.current_now      = current_in;
         rsp_beat_in.current_kind     = (sel_slot == SLOT_PITCH);
         rsp_beat_in.temperature_now  = temp_in;
         rsp_beat_in.turn_count       = turn_in;
         rsp_beat_in.multi_turn_angle = total;
      end
   end

   // Per-slot state update on the winning slot.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < SLOTS_USED; s++) begin
            angle_ff[s]   <= '0;
            offset_ff[s]  <= '0;
            turn_ff[s]    <= '0;
            count_ff[s]   <= '0;
            speed_ff[s]   <= '0;
            current_ff[s] <= '0;
            temp_ff[s]    <= '0;
         end
      end else if (adv) begin
         for (int s = 0; s < SLOTS_USED; s++) begin
            if (hit[s]) begin
               angle_ff[s]   <= angle_in;
               offset_ff[s]  <= offset_in;
               turn_ff[s]    <= turn_in;
               count_ff[s]   <= count_in;
               speed_ff[s]   <= speed_in;
               current_ff[s] <= current_in;
               temp_ff[s]    <= temp_in;
            end
         end
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= st_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_beat_ff <= rsp_beat_in;
      end
   end

   // An unmatched frame reports nothing but zeros.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_beat_ff.matched |->
         rsp_beat_ff.turn_count == '0 && rsp_beat_ff.multi_turn_angle == '0
         && rsp_beat_ff.calibrating == 1'b0)
      else $error("unmatched result carries nonzero fields");

   // While the offset is captured, angle equals offset, so only turns count.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_beat_ff.calibrating |->
         rsp_beat_ff.multi_turn_angle
            == {rsp_beat_ff.turn_count[TURN_W-TURN_SHIFT-1:0], {TURN_SHIFT{1'b0}}})
      else $error("total angle off during offset capture");

   // Commanded current is reported for the pitch slot alone.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_beat_ff.current_kind |-> rsp_beat_ff.motor_slot == SLOT_PITCH)
      else $error("current kind set on a slot other than pitch");

   // A waiting frame is not lost when the result side stalls.
   assert property (@(posedge clock) disable iff (reset)
      st_valid_ff && !out_free |=> st_valid_ff && $stable(st_beat_ff))
      else $error("input register changed while stalled");

   // The frame counter never runs past the capture length.
   for (genvar g = 0; g < SLOTS_USED; g++) begin : g_count_chk
      assert property (@(posedge clock) disable iff (reset)
         count_ff[g] <= CALIB_LAST)
         else $error("frame counter beyond capture length");
   end

endmodule

// ----- sim/tb_top.sv -----
// ----------------------------------------------------------------------------
// Motor feedback angle unwrapper testbench
// Drives CAN feedback frames into the unwrapper and checks every status beat
// against a cycle-free model of the per-slot calibration, unpacking and
// multi-turn unwrap. The frames are directed corner cases and random rotation
// sequences. They run under several motor identifier settings and with random
// backpressure on both channels.
// ----------------------------------------------------------------------------
module tb_top;
   import mfau_pkg::*;

   localparam int MOTOR_SLOTS  = 4;
   localparam int CALIB_FRAMES = 51;
   localparam int CYCLE_LIMIT  = 200000;

   logic              clock;
   logic              reset;
   logic              csr_wr_en;
   logic [IDX_W-1:0]  csr_index;
   logic [ID_W-1:0]   csr_wr_data;

   mfau_req_if req_ch ();
   mfau_rsp_if rsp_ch ();

   motor_feedback_angle_unwrapper_top #(
      .MOTOR_SLOTS  (MOTOR_SLOTS),
      .CALIB_FRAMES (CALIB_FRAMES)
   ) DUT (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   // Frames waiting to be sent and status beats waiting to arrive.
   req_beat_type frame_queue[$];
   rsp_beat_type expected_status[$];

   // Idle percentages of the sender and the receiver.
   int send_idle;
   int recv_idle;
   int mismatch_count = 0;
   int cycle_count    = 0;

   // Model copy of the identifier registers and the per-slot motor state.
   logic [ID_W-1:0]          motor_id    [ID_REGS] = '{RST_CHASSIS_ID, RST_TRIGGER_ID,
                                                       RST_YAW_ID, RST_PITCH_ID};
   logic [WORD_W-1:0]        angle_mem   [ID_REGS] = '{default: '0};
   logic [WORD_W-1:0]        offset_mem  [ID_REGS] = '{default: '0};
   logic [WORD_W-1:0]        speed_mem   [ID_REGS] = '{default: '0};
   logic [WORD_W-1:0]        current_mem [ID_REGS] = '{default: '0};
   logic [TEMP_W-1:0]        temp_mem    [ID_REGS] = '{default: '0};
   logic [TURN_W-1:0]        turns_mem   [ID_REGS] = '{default: '0};
   logic [COUNT_W-1:0]       frames_seen [ID_REGS] = '{default: '0};

   // Stimulus side bookkeeping: last angle and frame count sent per slot.
   logic [WORD_W-1:0]        gen_angle   [ID_REGS] = '{default: '0};
   int                       gen_frames  [ID_REGS] = '{default: 0};

   rsp_beat_type             want;

   // Clock generation.
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Print one line per mismatch and count it.
   task automatic report_mismatch(string msg);
      mismatch_count++;
      $display("mismatch: %s", msg);
   endtask

   // The lowest slot whose identifier matches wins; -1 when none matches.
   function automatic int find_slot(logic [ID_W-1:0] id);
      int hit;
      hit = -1;
      for (int s = MOTOR_SLOTS - 1; s >= 0; s--) begin
         if (motor_id[s] == id) hit = s;
      end
      return hit;
   endfunction

   // Apply one frame to the model state and return the expected status beat.
   function automatic rsp_beat_type unwrap_frame(req_beat_type f);
      rsp_beat_type r;
      int           slot;
      int           diff;
      r    = '0;
      slot = find_slot(f.std_id);
      if (slot < 0) return r;
      if (frames_seen[slot] < CALIB_FRAMES) begin
         // Power-on phase: the angle sets the offset and the stored angle only.
         r.calibrating     = 1'b1;
         frames_seen[slot] = frames_seen[slot] + 1'b1;
         angle_mem[slot]   = f.angle_word;
         offset_mem[slot]  = f.angle_word;
      end else begin
         diff              = int'(f.angle_word) - int'(angle_mem[slot]);
         angle_mem[slot]   = f.angle_word;
         speed_mem[slot]   = f.second_word;
         current_mem[slot] = f.third_word;
         if (slot != int'(SLOT_TRIGGER)) temp_mem[slot] = f.temp_byte;
         if (diff > int'(HALF_TURN)) begin
            turns_mem[slot] = turns_mem[slot] - 1'b1;
         end else if (diff < int'(NEG_HALF)) begin
            turns_mem[slot] = turns_mem[slot] + 1'b1;
         end
      end
      r.matched          = 1'b1;
      r.motor_slot       = slot[SLOT_W-1:0];
      r.angle_now        = angle_mem[slot];
      r.speed_now        = speed_mem[slot];
      r.current_now      = current_mem[slot];
      r.current_kind     = (slot == int'(SLOT_PITCH));
      r.temperature_now  = temp_mem[slot];
      r.turn_count       = turns_mem[slot];
      r.multi_turn_angle = (turns_mem[slot] << TURN_SHIFT) + {16'd0, angle_mem[slot]}
                           - {16'd0, offset_mem[slot]};
      return r;
   endfunction

   // Queue one frame and track what the slot it lands in has seen.
   task automatic queue_frame(logic [ID_W-1:0] id, logic [WORD_W-1:0] ang,
                              logic [WORD_W-1:0] w2, logic [WORD_W-1:0] w3,
                              logic [TEMP_W-1:0] t);
      req_beat_type f;
      int           slot;
      f.std_id      = id;
      f.angle_word  = ang;
      f.second_word = w2;
      f.third_word  = w3;
      f.temp_byte   = t;
      frame_queue.push_back(f);
      slot = find_slot(id);
      if (slot >= 0) begin
         gen_angle[slot] = ang;
         gen_frames[slot]++;
      end
   endtask

   // Mostly frames for configured motors with plausible rotation, some noise.
   task automatic queue_random_frame();
      int                pick;
      int                slot;
      int                mode;
      logic [ID_W-1:0]   id;
      logic [WORD_W-1:0] prev;
      logic [WORD_W-1:0] ang;
      pick = $urandom_range(99);
      slot = $urandom_range(MOTOR_SLOTS - 1);
      id   = motor_id[slot];
      if (pick < 12) begin
         id = ID_W'($urandom_range(2047));
      end else if (pick < 18) begin
         id = motor_id[slot] ^ (11'd1 << $urandom_range(ID_W - 1));
      end
      slot = find_slot(id);
      prev = (slot >= 0) ? gen_angle[slot] : '0;
      mode = $urandom_range(9);
      if (mode < 6) begin
         // Smooth rotation inside one 13-bit turn, wrapping at the ends.
         ang = WORD_W'((int'(prev) + int'($urandom_range(4000)) - 2000) & 8191);
      end else if (mode < 8) begin
         // Jumps right at the half-turn threshold.
         if ($urandom_range(1) == 1) begin
            ang = prev + WORD_W'(4096 + $urandom_range(1));
         end else begin
            ang = prev - WORD_W'(4096 + $urandom_range(1));
         end
      end else begin
         ang = WORD_W'($urandom_range(65535));
      end
      queue_frame(id, ang, WORD_W'($urandom), WORD_W'($urandom), TEMP_W'($urandom));
   endtask

   // Wait until every frame has been sent and every status beat has arrived.
   task automatic settle();
      @(negedge clock);
      while (frame_queue.size() != 0 || req_ch.valid || expected_status.size() != 0) begin
         @(negedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   // Write one identifier register; the model takes it at once since all is idle.
   task automatic write_motor_id(logic [IDX_W-1:0] idx, logic [ID_W-1:0] value);
      @(posedge clock);
      csr_wr_en     <= 1'b1;
      csr_index     <= idx;
      csr_wr_data   <= value;
      motor_id[idx]  = value;
   endtask

   // Rewrite all four motor identifiers once the block is idle.
   task automatic load_motor_ids(logic [ID_W-1:0] chassis, logic [ID_W-1:0] trigger,
                                 logic [ID_W-1:0] yaw, logic [ID_W-1:0] pitch);
      settle();
      write_motor_id(CSR_CHASSIS_ID, chassis);
      write_motor_id(CSR_TRIGGER_ID, trigger);
      write_motor_id(CSR_YAW_ID, yaw);
      write_motor_id(CSR_PITCH_ID, pitch);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   // Frame driver: predict each accepted beat, then offer the next one.
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            expected_status.push_back(unwrap_frame(req_ch.data));
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (frame_queue.size() != 0 && $urandom_range(99) >= send_idle) begin
               req_ch.data  <= frame_queue.pop_front();
               req_ch.valid <= 1'b1;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Status monitor: compare each accepted beat with the oldest expectation.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_status.size() == 0) begin
               report_mismatch($sformatf("status beat for slot %0d with no frame outstanding",
                                         rsp_ch.data.motor_slot));
            end else begin
               want = expected_status.pop_front();
               if (rsp_ch.data.matched !== want.matched)
                  report_mismatch($sformatf("matched got %0d want %0d",
                                            rsp_ch.data.matched, want.matched));
               if (rsp_ch.data.motor_slot !== want.motor_slot)
                  report_mismatch($sformatf("motor_slot got %0d want %0d",
                                            rsp_ch.data.motor_slot, want.motor_slot));
               if (rsp_ch.data.calibrating !== want.calibrating)
                  report_mismatch($sformatf("calibrating got %0d want %0d",
                                            rsp_ch.data.calibrating, want.calibrating));
               if (rsp_ch.data.angle_now !== want.angle_now)
                  report_mismatch($sformatf("angle_now got %0d want %0d",
                                            rsp_ch.data.angle_now, want.angle_now));
               if (rsp_ch.data.speed_now !== want.speed_now)
                  report_mismatch($sformatf("speed_now got %0d want %0d",
                                            rsp_ch.data.speed_now, want.speed_now));
               if (rsp_ch.data.current_now !== want.current_now)
                  report_mismatch($sformatf("current_now got %0d want %0d",
                                            rsp_ch.data.current_now, want.current_now));
               if (rsp_ch.data.current_kind !== want.current_kind)
                  report_mismatch($sformatf("current_kind got %0d want %0d",
                                            rsp_ch.data.current_kind, want.current_kind));
               if (rsp_ch.data.temperature_now !== want.temperature_now)
                  report_mismatch($sformatf("temperature_now got %0d want %0d",
                                            rsp_ch.data.temperature_now,
                                            want.temperature_now));
               if (rsp_ch.data.turn_count !== want.turn_count)
                  report_mismatch($sformatf("turn_count got %0d want %0d",
                                            rsp_ch.data.turn_count, want.turn_count));
               if (rsp_ch.data.multi_turn_angle !== want.multi_turn_angle)
                  report_mismatch($sformatf("multi_turn_angle got %0d want %0d",
                                            rsp_ch.data.multi_turn_angle,
                                            want.multi_turn_angle));
            end
         end
         rsp_ch.ready <= ($urandom_range(99) >= recv_idle);
      end
   end

   // Watchdog on the total run length.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb_top failed");
      $finish;
   end

   // Test sequence.
   initial begin
      int  n;
      bit  all_calibrated;
      reset        = 1'b1;
      csr_wr_en    = 1'b0;
      csr_index    = '0;
      csr_wr_data  = '0;
      req_ch.valid = 1'b0;
      req_ch.data  = '0;
      rsp_ch.ready = 1'b0;
      send_idle    = 12;
      recv_idle    = 88;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Reset identifiers: unmatched extremes and one calibration frame per slot.
      queue_frame(11'd0, 16'h0000, 16'h0000, 16'h0000, 8'h00);
      queue_frame(11'd2047, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
      queue_frame(RST_CHASSIS_ID, 16'h0000, 16'h8000, 16'h7FFF, 8'h00);
      queue_frame(RST_TRIGGER_ID, 16'hFFFF, 16'h8000, 16'h7FFF, 8'hFF);
      queue_frame(RST_YAW_ID, 16'd8191, 16'h7FFF, 16'h8000, 8'h80);
      queue_frame(RST_PITCH_ID, 16'd4096, 16'h0001, 16'hFFFF, 8'h01);
      queue_frame(11'd514, 16'h5555, 16'hAAAA, 16'h5555, 8'hAA);

      // Random traffic until every slot is well past calibration.
      n = 0;
      do begin
         queue_random_frame();
         n++;
         all_calibrated = 1'b1;
         for (int s = 0; s < MOTOR_SLOTS; s++) begin
            if (gen_frames[s] < CALIB_FRAMES + 4) all_calibrated = 1'b0;
         end
      end while (n < 250 || !all_calibrated);

      // Extreme identifiers; yaw shares the chassis identifier and never wins.
      load_motor_ids(11'd0, 11'd2047, 11'd0, 11'd1024);
      send_idle = 88;
      recv_idle = 12;
      queue_frame(11'd0, 16'd100, 16'd10, 16'd20, 8'd30);
      queue_frame(11'd0, 16'd4196, 16'd11, 16'd21, 8'd31);
      queue_frame(11'd0, 16'd99, 16'd12, 16'd22, 8'd32);
      queue_frame(11'd0, 16'd4196, 16'd13, 16'd23, 8'd33);
      queue_frame(11'd0, 16'd8000, 16'd14, 16'd24, 8'd34);
      queue_frame(11'd0, 16'd0, 16'd15, 16'd25, 8'd35);
      queue_frame(11'd2047, 16'hFFFF, 16'h8000, 16'h7FFF, 8'hAA);
      queue_frame(11'd2047, 16'h0000, 16'h7FFF, 16'h8000, 8'h55);
      queue_frame(11'd1024, 16'd5000, 16'hFFFF, 16'h8000, 8'hFF);
      queue_frame(11'd1024, 16'd500, 16'h0000, 16'h7FFF, 8'h00);
      queue_frame(RST_YAW_ID, 16'd1234, 16'd1, 16'd2, 8'd3);
      repeat (120) queue_random_frame();

      // Alternating bit patterns, then back to the reset identifiers.
      load_motor_ids(11'd1365, 11'd682, 11'd2047, 11'd0);
      send_idle = 0;
      recv_idle = 0;
      repeat (80) queue_random_frame();
      load_motor_ids(RST_CHASSIS_ID, RST_TRIGGER_ID, RST_YAW_ID, RST_PITCH_ID);
      repeat (60) queue_random_frame();

      settle();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule
